/* hdl/tfn_pkg.sv */
// ---------------------------------------------------------------------------
// tfn_pkg
// Types and fixed widths shared by the triangle face normal unit.
// ---------------------------------------------------------------------------
package tfn_pkg;

  // vertex coordinate width (signed Q4.12 at 16 bits)
  localparam int COORD_BITS = 16;
  localparam int OUT_W      = 16;

  // edges are pre-shifted for wide coordinates so the cross product fits
  localparam int EDGE_DROP  = (COORD_BITS > 30) ? COORD_BITS - 30 : 0;
  localparam int EW         = COORD_BITS + 1 - EDGE_DROP;  // edge width
  localparam int PW         = 2 * EW;                      // product width
  localparam int CW         = PW + 1;                      // cross width
  localparam int BLW        = $clog2(CW + 1);              // bit length width

  localparam int UBITS      = 15;                          // scaled magnitude
  localparam int SQW        = 2 * UBITS;                   // one square
  localparam int SW         = SQW + 2;                     // sum of squares
  localparam int LEN_SH     = 28;                          // S * 2^28
  localparam int XW         = SW + LEN_SH;                 // sqrt radicand
  localparam int RTW        = XW / 2;                      // sqrt root
  localparam int FRAC_SH    = 29;                          // u * 2^29
  localparam int NW         = UBITS + FRAC_SH + 1;         // numerator
  localparam int DW         = RTW + 1;                     // divisor 2*len
  localparam int QW         = 16;                          // quotient

  localparam logic [QW-1:0] UNIT_Q14 = QW'(16384);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] a_z;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] b_z;
    logic signed [COORD_BITS-1:0] c_x;
    logic signed [COORD_BITS-1:0] c_y;
    logic signed [COORD_BITS-1:0] c_z;
  } tri_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] norm_x;
    logic signed [OUT_W-1:0] norm_y;
    logic signed [OUT_W-1:0] norm_z;
    logic                    degenerate;
  } norm_out_t;

endpackage

/* hdl/triangle_face_normal_unit.sv */
// ---------------------------------------------------------------------------
// triangle_face_normal_unit
// Fully pipelined unit face normal of a triangle, Q4.12 in, Q1.14 out.
// ---------------------------------------------------------------------------
// Usage:
//   Drive a triangle on tri_in and raise start for one cycle per item. busy
//   is held low, so an item is taken at every edge where start is high: one
//   item per clock, back to back, with no gaps needed.
//   Each item yields one result on the result port, marked by strobe for
//   exactly one cycle. Results keep item order. The pipeline holds
//   8 stages of edges, cross product, magnitude scaling and sum of
//   squares, 15 stages of square root (two root bits per stage), one
//   numerator stage, 8 stages of division (two quotient bits per stage,
//   three lanes side by side) and the output reg.
//   The receiver cannot hold results off, so nothing ever stalls; every
//   stage advances each clock and valid bits ride along with the data.
//   rst (synchronous, active high) clears all valid bits; items in flight
//   are dropped and strobe stays low until new items arrive.
//   A zero cross product gives a zero normal with degenerate set.
// ---------------------------------------------------------------------------
module triangle_face_normal_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  tfn_pkg::tri_in_t    tri_in,
  output logic                strobe,
  output tfn_pkg::norm_out_t  result
);
  import tfn_pkg::*;

  localparam int SQ_ST = RTW / 2;   // sqrt stages, two bits each
  localparam int DV_ST = QW / 2;    // divide stages, two bits each
  localparam int SRW   = RTW + 3;   // sqrt remainder width

  typedef struct packed {
    logic                       deg;
    logic [2:0]                 neg;
    logic [2:0][UBITS-1:0]      u;
  } side_t;

  // edge e = q - p, floor-shifted for wide coordinates
  function automatic logic signed [EW-1:0] edge_of(
    input logic signed [COORD_BITS-1:0] p,
    input logic signed [COORD_BITS-1:0] q
  );
    logic signed [COORD_BITS:0] d;
    d = (COORD_BITS+1)'(q) - (COORD_BITS+1)'(p);
    return EW'(d >>> EDGE_DROP);
  endfunction

  assign busy = 1'b0;

  // ---- stage 1: edges ----
  logic                   v1;
  logic signed [EW-1:0]   e1 [3];
  logic signed [EW-1:0]   e2 [3];

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start & ~busy;
    e1[0] <= edge_of(tri_in.a_x, tri_in.b_x);
    e1[1] <= edge_of(tri_in.a_y, tri_in.b_y);
    e1[2] <= edge_of(tri_in.a_z, tri_in.b_z);
    e2[0] <= edge_of(tri_in.a_x, tri_in.c_x);
    e2[1] <= edge_of(tri_in.a_y, tri_in.c_y);
    e2[2] <= edge_of(tri_in.a_z, tri_in.c_z);
  end

  // ---- stage 2: six partial products ----
  logic                   v2;
  logic signed [PW-1:0]   prod [6];

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    prod[0] <= e1[1] * e2[2];
    prod[1] <= e1[2] * e2[1];
    prod[2] <= e1[2] * e2[0];
    prod[3] <= e1[0] * e2[2];
    prod[4] <= e1[0] * e2[1];
    prod[5] <= e1[1] * e2[0];
  end

  // ---- stage 3: cross product ----
  logic                   v3;
  logic signed [CW-1:0]   cr [3];

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
    for (int i = 0; i < 3; i++) begin
      cr[i] <= CW'(prod[2*i]) - CW'(prod[2*i+1]);
    end
  end

  // ---- stage 4: sign and magnitude ----
  logic                   v4;
  logic [CW-1:0]          mag4 [3];
  logic [2:0]             neg4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
    for (int i = 0; i < 3; i++) begin
      neg4[i] <= cr[i][CW-1];
      mag4[i] <= cr[i][CW-1] ? CW'(-cr[i]) : CW'(cr[i]);
    end
  end

  // ---- stage 5: bit length of the largest magnitude ----
  // bit length of the max equals bit length of the OR of all three
  logic                   v5;
  logic [CW-1:0]          mag5 [3];
  logic [2:0]             neg5;
  logic                   deg5;
  logic [BLW-1:0]         bl5;
  logic [CW-1:0]          orm;
  logic [BLW-1:0]         bl_c;

  always_comb begin
    orm  = mag4[0] | mag4[1] | mag4[2];
    bl_c = '0;
    for (int i = 0; i < CW; i++) begin
      if (orm[i]) bl_c = BLW'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else     v5 <= v4;
    mag5 <= mag4;
    neg5 <= neg4;
    deg5 <= (orm == '0);
    bl5  <= bl_c;
  end

  // ---- stage 6: scale so the largest lands in [2^14, 2^15) ----
  logic                   v6;
  side_t                  sd6;
  logic [BLW-1:0]         shl_c;
  logic [BLW-1:0]         shr_c;

  assign shl_c = BLW'(UBITS) - bl5;
  assign shr_c = bl5 - BLW'(UBITS);

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else     v6 <= v5;
    sd6.deg <= deg5;
    sd6.neg <= neg5;
    for (int i = 0; i < 3; i++) begin
      if (bl5 <= BLW'(UBITS)) sd6.u[i] <= UBITS'(mag5[i] << shl_c);
      else                    sd6.u[i] <= UBITS'(mag5[i] >> shr_c);
    end
  end

  // ---- stage 7: squares ----
  logic                   v7;
  side_t                  sd7;
  logic [SQW-1:0]         sq7 [3];

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else     v7 <= v6;
    sd7 <= sd6;
    for (int i = 0; i < 3; i++) begin
      sq7[i] <= sd6.u[i] * sd6.u[i];
    end
  end

  // ---- stage 8: sum of squares, sqrt pipe entry ----
  logic                   sq_v    [SQ_ST+1];
  side_t                  sq_sd   [SQ_ST+1];
  logic [SRW-1:0]         sq_rem  [SQ_ST+1];
  logic [RTW-1:0]         sq_root [SQ_ST+1];
  logic [XW-1:0]          sq_x    [SQ_ST+1];

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else     sq_v[0] <= v7;
    sq_sd[0]   <= sd7;
    sq_rem[0]  <= '0;
    sq_root[0] <= '0;
    sq_x[0]    <= {SW'(sq7[0]) + SW'(sq7[1]) + SW'(sq7[2]), {LEN_SH{1'b0}}};
  end

  // ---- square root: two root bits per stage ----
  for (genvar k = 0; k < SQ_ST; k++) begin : g_sqrt
    logic [SRW-1:0] n_rem;
    logic [RTW-1:0] n_root;
    logic [XW-1:0]  n_x;

    always_comb begin
      logic [SRW-1:0] rem;
      logic [SRW-1:0] r2;
      logic [SRW-1:0] t;
      logic [RTW-1:0] root;
      logic [XW-1:0]  x;
      rem  = sq_rem[k];
      root = sq_root[k];
      x    = sq_x[k];
      for (int j = 0; j < 2; j++) begin
        r2 = {rem[SRW-3:0], x[XW-1 -: 2]};
        t  = SRW'({root, 2'b01});
        if (r2 >= t) begin
          rem  = r2 - t;
          root = {root[RTW-2:0], 1'b1};
        end else begin
          rem  = r2;
          root = {root[RTW-2:0], 1'b0};
        end
        x = x << 2;
      end
      n_rem  = rem;
      n_root = root;
      n_x    = x;
    end

    always_ff @(posedge clk) begin
      if (rst) sq_v[k+1] <= 1'b0;
      else     sq_v[k+1] <= sq_v[k];
      sq_sd[k+1]   <= sq_sd[k];
      sq_rem[k+1]  <= n_rem;
      sq_root[k+1] <= n_root;
      sq_x[k+1]    <= n_x;
    end
  end

  // ---- numerator u*2^29 + len, divisor 2*len ----
  logic                   dv_v   [DV_ST+1];
  side_t                  dv_sd  [DV_ST+1];
  logic [DW-1:0]          dv_den [DV_ST+1];
  logic [DW-1:0]          dv_rem [DV_ST+1][3];
  logic [QW-1:0]          dv_lo  [DV_ST+1][3];
  logic [NW-1:0]          numer  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      numer[i] = NW'({sq_sd[SQ_ST].u[i], {FRAC_SH{1'b0}}}) + NW'(sq_root[SQ_ST]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else     dv_v[0] <= sq_v[SQ_ST];
    dv_sd[0]  <= sq_sd[SQ_ST];
    dv_den[0] <= {sq_root[SQ_ST], 1'b0};
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] <= DW'(numer[i][NW-1:QW]);
      dv_lo[0][i]  <= numer[i][QW-1:0];
    end
  end

  // ---- restoring division: two quotient bits per stage, three lanes ----
  // low word shifts numerator bits out and quotient bits in
  for (genvar k = 0; k < DV_ST; k++) begin : g_div
    logic [DW-1:0] n_rem [3];
    logic [QW-1:0] n_lo  [3];

    always_comb begin
      logic [DW:0]   r2;
      logic [DW-1:0] rem;
      logic [QW-1:0] lo;
      logic          qb;
      for (int i = 0; i < 3; i++) begin
        rem = dv_rem[k][i];
        lo  = dv_lo[k][i];
        for (int j = 0; j < 2; j++) begin
          r2 = {rem, lo[QW-1]};
          qb = (r2 >= (DW+1)'(dv_den[k]));
          if (qb) rem = DW'(r2 - (DW+1)'(dv_den[k]));
          else    rem = DW'(r2);
          lo = {lo[QW-2:0], qb};
        end
        n_rem[i] = rem;
        n_lo[i]  = lo;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) dv_v[k+1] <= 1'b0;
      else     dv_v[k+1] <= dv_v[k];
      dv_sd[k+1]  <= dv_sd[k];
      dv_den[k+1] <= dv_den[k];
      dv_rem[k+1] <= n_rem;
      dv_lo[k+1]  <= n_lo;
    end
  end

  // ---- output: cap at one, apply sign, force zero when degenerate ----
  logic [QW-1:0]          qcap [3];
  logic [OUT_W-1:0]       comp [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qcap[i] = (dv_lo[DV_ST][i] > UNIT_Q14) ? UNIT_Q14 : dv_lo[DV_ST][i];
      if (dv_sd[DV_ST].deg)         comp[i] = '0;
      else if (dv_sd[DV_ST].neg[i]) comp[i] = OUT_W'(-qcap[i]);
      else                          comp[i] = OUT_W'(qcap[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) strobe <= 1'b0;
    else     strobe <= dv_v[DV_ST];
    result.norm_x     <= comp[0];
    result.norm_y     <= comp[1];
    result.norm_z     <= comp[2];
    result.degenerate <= dv_sd[DV_ST].deg;
  end

endmodule
